// ===== hdl/wpf_pkg.sv =====
// Shared types, widths and codes of the waypoint path follower.
package wpf_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int COORD_W = 24;
   localparam int TIME_W  = 32;
   localparam int SCALE_W = 16;
   localparam int SPEED_W = 24;
   localparam int TICK_W  = 16;
   localparam int LEN_W   = 25;
   localparam int PROD_W  = 50;
   localparam int CMD_W   = 3;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 32;
   localparam int REQ_D_W = 136;
   localparam int RSP_D_W = 80;

   localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd256;

   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

   localparam logic [CSR_A_W-1:0] REG_ENABLED      = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_SPEED        = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_PING_PONG    = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_START_DELAY  = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_START_PAUSED = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [TIME_W-1:0]  dwell;
      logic [SCALE_W-1:0] width;
      logic [SCALE_W-1:0] height;
   } point_type;

   typedef struct packed {
      logic start;
      logic sqrt;
   } iter_ctl_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] result;
   } iter_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_LD_CUR,
      ST_RD_NXT,
      ST_LD_NXT,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_ADV,
      ST_MUL0,
      ST_MUL1,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/wpf_ram.sv =====
// Generic single write port RAM with a registered read port.
module wpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/wpf_iter.sv =====
// Bit-serial divider and square root unit sharing one subtract and compare.
module wpf_iter import wpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  iter_ctl_type      ctl,
   input  logic [PROD_W-1:0] operand,
   input  logic [LEN_W-1:0]  divisor,
   output iter_stat_type     stat
);

   localparam int REM_W  = LEN_W + 3;
   localparam int STEP_W = $clog2(PROD_W);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(PROD_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(PROD_W / 2 - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              sqrt_ff, sqrt_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] work_ff, work_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  root_ff, root_in;
   logic [LEN_W-1:0]  dvs_ff, dvs_in;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic [REM_W-1:0] diff;
   logic             ge;

   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff[REM_W-3:0], work_ff[PROD_W-1:PROD_W-2]};
         trial  = {1'b0, root_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], work_ff[PROD_W-1]};
         trial  = REM_W'(dvs_ff);
      end
      ge   = rem_sh >= trial;
      diff = rem_sh - trial;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         sqrt_in = ctl.sqrt;
         cnt_in  = ctl.sqrt ? SQRT_LAST : DIV_LAST;
         work_in = operand;
         rem_in  = '0;
         root_in = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff : rem_sh;
         if (sqrt_ff) begin
            work_in = {work_ff[PROD_W-3:0], 2'b00};
            root_in = {root_ff[LEN_W-2:0], ge};
         end else begin
            work_in = {work_ff[PROD_W-2:0], ge};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      dvs_ff  <= dvs_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = sqrt_ff ? root_ff : work_ff[LEN_W-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff) else $error("iterative unit started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("iterative unit done while still busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("iterative unit done held for two cycles");

endmodule

// ===== hdl/waypoint_path_follower.sv =====
// Top level of the waypoint path follower: sequencer, waypoint table and datapath.
// Push, clear, pause and restart words give no result; after a tick the next word is taken after the result.
// A tick that reports no position goes straight to the done state, a dwell reads the current waypoint first.
// A moving tick is paced by the serial unit: one 25-step square root per segment length
// and four 50-step divisions.
// Synchronous reset restores the register defaults and empties the waypoint table.
module waypoint_path_follower import wpf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // command
   input  logic [CMD_W-1:0]   req_tuser,
   // tick_length, point_x, point_y, point_dwell, point_width, point_height, resume, zero pad
   input  logic [REQ_D_W-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // position_valid
   output logic               rsp_tuser,
   // pos_x, pos_y, scale_x, scale_y
   output logic [RSP_D_W-1:0] rsp_tdata,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_D_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic               enabled_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic               ping_pong_ff;
   logic [TIME_W-1:0]  start_delay_ff;
   logic               start_paused_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [IDX_W-1:0]   nxt_idx_ff, nxt_idx_in;
   logic               fwd_ff, fwd_in;
   logic [TIME_W-1:0]  dist_ff, dist_in;
   logic [TIME_W-1:0]  dwell_ff, dwell_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic               paused_ff, paused_in;
   logic               advanced_ff, advanced_in;
   logic [1:0]         lane_ff, lane_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;

   logic [TICK_W-1:0]  dt_ff, dt_in;
   logic [SPEED_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   d_ff, d_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   point_type          cpt_ff, cpt_in;
   point_type          npt_ff, npt_in;
   logic               res_valid_ff, res_valid_in;
   logic [COORD_W-1:0] res_x_ff, res_x_in;
   logic [COORD_W-1:0] res_y_ff, res_y_in;
   logic [SCALE_W-1:0] res_w_ff, res_w_in;
   logic [SCALE_W-1:0] res_h_ff, res_h_in;
   logic               rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_D_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic          req_fire;
   logic          ram_we;
   logic [IDX_W-1:0] ram_raddr;
   point_type     ram_wdata;
   point_type     ram_rdata;
   logic [$bits(point_type)-1:0] ram_rbits;
   iter_ctl_type  iter_ctl;
   iter_stat_type iter_stat;

   logic [TICK_W-1:0]  f_tick;
   logic               f_resume;
   logic               run_ok;
   logic [IDX_W-1:0]   cur_fixed;
   logic               delay_done;
   logic               move_go;
   logic [TIME_W-1:0]  dist_sum;
   logic               seg_end;
   logic               fwd_new;
   logic [TIME_W-1:0]  dist_eff;
   logic               rsp_free;

   logic signed [LEN_W-1:0] dlt_x, dlt_y;
   logic [LEN_W-1:0]   mag_x, mag_y;
   logic [LEN_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  prod;
   logic [LEN_W-1:0]   lerp_base;
   logic               lerp_neg;
   logic [LEN_W-1:0]   lerp_val;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] cur,
                                                 input logic fwd, input logic pp,
                                                 input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] inc;
      logic [CNT_W-1:0] last;
      inc  = CNT_W'(cur) + 1'b1;
      last = cnt - 1'b1;
      if (pp && !fwd) begin
         return (cur == '0) ? last[IDX_W-1:0] : cur - 1'b1;
      end
      return (inc == cnt) ? '0 : inc[IDX_W-1:0];
   endfunction

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign f_tick    = req_tdata[15:0];
   assign f_resume  = req_tdata[128];
   assign ram_wdata.x      = req_tdata[39:16];
   assign ram_wdata.y      = req_tdata[63:40];
   assign ram_wdata.dwell  = req_tdata[95:64];
   assign ram_wdata.width  = req_tdata[111:96];
   assign ram_wdata.height = req_tdata[127:112];
   assign ram_rdata = point_type'(ram_rbits);

   assign run_ok     = enabled_ff && (count_ff > CNT_W'(1));
   assign cur_fixed  = (CNT_W'(cur_idx_ff) >= count_ff) ? '0 : cur_idx_ff;
   assign delay_done = start_ff > start_delay_ff;
   assign move_go    = dwell_ff > ram_rdata.dwell;
   assign dist_sum   = sat_add(dist_ff, TIME_W'(step_ff));
   assign seg_end    = !advanced_ff && (dist_sum >= TIME_W'(len_ff));
   assign dist_eff   = advanced_ff ? dist_ff : dist_sum;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      fwd_new = fwd_ff;
      if (ping_pong_ff) begin
         if (fwd_ff && (CNT_W'(nxt_idx_ff) == count_ff - 1'b1)) begin
            fwd_new = 1'b0;
         end else if (!fwd_ff && (nxt_idx_ff == '0)) begin
            fwd_new = 1'b1;
         end
      end
   end

   assign dlt_x = $signed({npt_ff.x[COORD_W-1], npt_ff.x}) - $signed({cpt_ff.x[COORD_W-1], cpt_ff.x});
   assign dlt_y = $signed({npt_ff.y[COORD_W-1], npt_ff.y}) - $signed({cpt_ff.y[COORD_W-1], cpt_ff.y});
   assign mag_x = dlt_x[LEN_W-1] ? LEN_W'(-dlt_x) : LEN_W'(dlt_x);
   assign mag_y = dlt_y[LEN_W-1] ? LEN_W'(-dlt_y) : LEN_W'(dlt_y);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RD_NXT: begin
            mul_a = LEN_W'(speed_ff);
            mul_b = LEN_W'(dt_ff);
         end
         ST_SQ_X: begin
            mul_a = mag_x;
            mul_b = mag_x;
         end
         ST_SQ_Y: begin
            mul_a = mag_y;
            mul_b = mag_y;
         end
         ST_MUL0: begin
            if (!lane_ff[1]) begin
               mul_a = lane_ff[0] ? mag_y : mag_x;
               mul_b = d_ff;
            end else begin
               mul_a = LEN_W'(lane_ff[0] ? cpt_ff.height : cpt_ff.width);
               mul_b = len_ff - d_ff;
            end
         end
         ST_MUL1: begin
            mul_a = LEN_W'(lane_ff[0] ? npt_ff.height : npt_ff.width);
            mul_b = d_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign lerp_base = lane_ff[0] ? {cpt_ff.y[COORD_W-1], cpt_ff.y}
                                 : {cpt_ff.x[COORD_W-1], cpt_ff.x};
   assign lerp_neg  = lane_ff[0] ? dlt_y[LEN_W-1] : dlt_x[LEN_W-1];
   assign lerp_val  = lerp_neg ? lerp_base - iter_stat.result : lerp_base + iter_stat.result;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == CMD_TICK)) begin
               state_in = (run_ok && delay_done) ? ST_RD_CUR : ST_DONE;
            end
         end
         ST_RD_CUR:    state_in = ST_LD_CUR;
         ST_LD_CUR:    state_in = move_go ? ST_RD_NXT : ST_DONE;
         ST_RD_NXT:    state_in = ST_LD_NXT;
         ST_LD_NXT:    state_in = ST_SQ_X;
         ST_SQ_X:      state_in = ST_SQ_Y;
         ST_SQ_Y:      state_in = ST_SQRT_GO;
         ST_SQRT_GO:   state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: state_in = iter_stat.done ? ST_ADV : ST_SQRT_WAIT;
         ST_ADV: begin
            if (seg_end) begin
               state_in = ST_RD_NXT;
            end else begin
               state_in = (len_ff == '0) ? ST_DONE : ST_MUL0;
            end
         end
         ST_MUL0:      state_in = lane_ff[1] ? ST_MUL1 : ST_DIV_GO;
         ST_MUL1:      state_in = ST_DIV_GO;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (iter_stat.done) begin
               state_in = (lane_ff == 2'd3) ? ST_DONE : ST_MUL0;
            end
         end
         ST_DONE:      state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      cur_idx_in    = cur_idx_ff;
      nxt_idx_in    = nxt_idx_ff;
      fwd_in        = fwd_ff;
      dist_in       = dist_ff;
      dwell_in      = dwell_ff;
      start_in      = start_ff;
      paused_in     = paused_ff;
      advanced_in   = advanced_ff;
      lane_in       = lane_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      dt_in         = dt_ff;
      step_in       = step_ff;
      len_in        = len_ff;
      d_in          = d_ff;
      acc_in        = acc_ff;
      cpt_in        = cpt_ff;
      npt_in        = npt_ff;
      res_valid_in  = res_valid_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_w_in      = res_w_ff;
      res_h_in      = res_h_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      ram_we        = 1'b0;
      ram_raddr     = cur_idx_ff;
      iter_ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  CMD_TICK: begin
                     dt_in        = paused_ff ? '0 : f_tick;
                     advanced_in  = 1'b0;
                     res_valid_in = 1'b0;
                     res_x_in     = '0;
                     res_y_in     = '0;
                     res_w_in     = SCALE_ONE;
                     res_h_in     = SCALE_ONE;
                     if (run_ok) begin
                        cur_idx_in = cur_fixed;
                        if (!delay_done) begin
                           start_in = sat_add(start_ff, TIME_W'(paused_ff ? '0 : f_tick));
                        end
                     end
                  end
                  CMD_PUSH: begin
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: count_in = '0;
                  CMD_PAUSE: paused_in = !f_resume;
                  CMD_RESTART: begin
                     fwd_in     = 1'b1;
                     cur_idx_in = '0;
                     dist_in    = '0;
                     dwell_in   = '0;
                     start_in   = '0;
                     paused_in  = start_paused_ff;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_LD_CUR: begin
            cpt_in = ram_rdata;
            if (move_go) begin
               nxt_idx_in = next_idx(cur_idx_ff, fwd_ff, ping_pong_ff, count_ff);
            end else begin
               res_valid_in = 1'b1;
               res_x_in     = ram_rdata.x;
               res_y_in     = ram_rdata.y;
               dwell_in     = sat_add(dwell_ff, TIME_W'(dt_ff));
            end
         end
         ST_RD_NXT: begin
            ram_raddr = nxt_idx_ff;
            step_in   = prod[SPEED_W+TICK_W-1:TICK_W];
         end
         ST_LD_NXT: npt_in = ram_rdata;
         ST_SQ_X:   acc_in = prod;
         ST_SQ_Y:   acc_in = acc_ff + prod;
         ST_SQRT_GO: begin
            iter_ctl.start = 1'b1;
            iter_ctl.sqrt  = 1'b1;
         end
         ST_SQRT_WAIT: begin
            if (iter_stat.done) begin
               len_in = iter_stat.result;
            end
         end
         ST_ADV: begin
            if (seg_end) begin
               dist_in     = dist_sum - TIME_W'(len_ff);
               dwell_in    = '0;
               fwd_in      = fwd_new;
               cur_idx_in  = nxt_idx_ff;
               cpt_in      = npt_ff;
               nxt_idx_in  = next_idx(nxt_idx_ff, fwd_new, ping_pong_ff, count_ff);
               advanced_in = 1'b1;
            end else begin
               dist_in      = dist_eff;
               res_valid_in = 1'b1;
               lane_in      = '0;
               d_in         = (dist_eff < TIME_W'(len_ff)) ? dist_eff[LEN_W-1:0] : len_ff;
               if (len_ff == '0) begin
                  res_x_in = cpt_ff.x;
                  res_y_in = cpt_ff.y;
                  res_w_in = cpt_ff.width;
                  res_h_in = cpt_ff.height;
               end
            end
         end
         ST_MUL0: acc_in = prod;
         ST_MUL1: acc_in = acc_ff + prod;
         ST_DIV_GO: iter_ctl.start = 1'b1;
         ST_DIV_WAIT: begin
            if (iter_stat.done) begin
               lane_in = lane_ff + 1'b1;
               case (lane_ff)
                  2'd0:    res_x_in = lerp_val[COORD_W-1:0];
                  2'd1:    res_y_in = lerp_val[COORD_W-1:0];
                  2'd2:    res_w_in = iter_stat.result[SCALE_W-1:0];
                  default: res_h_in = iter_stat.result[SCALE_W-1:0];
               endcase
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_valid_ff;
               rsp_tdata_in  = {res_h_ff, res_w_ff, res_y_ff, res_x_ff};
            end
         end
         default: begin
            iter_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         enabled_ff      <= 1'b1;
         speed_ff        <= '0;
         ping_pong_ff    <= 1'b0;
         start_delay_ff  <= '0;
         start_paused_ff <= 1'b0;
         count_ff        <= '0;
         cur_idx_ff      <= '0;
         nxt_idx_ff      <= '0;
         fwd_ff          <= 1'b1;
         dist_ff         <= '0;
         dwell_ff        <= '0;
         start_ff        <= '0;
         paused_ff       <= 1'b0;
         advanced_ff     <= 1'b0;
         lane_ff         <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cur_idx_ff    <= cur_idx_in;
         nxt_idx_ff    <= nxt_idx_in;
         fwd_ff        <= fwd_in;
         dist_ff       <= dist_in;
         dwell_ff      <= dwell_in;
         start_ff      <= start_in;
         paused_ff     <= paused_in;
         advanced_ff   <= advanced_in;
         lane_ff       <= lane_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            case (csr_addr)
               REG_ENABLED:      enabled_ff      <= csr_wdata[0];
               REG_SPEED:        speed_ff        <= csr_wdata[SPEED_W-1:0];
               REG_PING_PONG:    ping_pong_ff    <= csr_wdata[0];
               REG_START_DELAY:  start_delay_ff  <= csr_wdata[TIME_W-1:0];
               REG_START_PAUSED: start_paused_ff <= csr_wdata[0];
               default:          enabled_ff      <= enabled_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      step_ff      <= step_in;
      len_ff       <= len_in;
      d_ff         <= d_in;
      acc_ff       <= acc_in;
      cpt_ff       <= cpt_in;
      npt_ff       <= npt_in;
      res_valid_ff <= res_valid_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_w_ff     <= res_w_in;
      res_h_ff     <= res_h_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   wpf_ram #(
      .WIDTH ($bits(point_type)),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );

   wpf_iter u_iter (
      .clock   (clock),
      .reset   (reset),
      .ctl     (iter_ctl),
      .operand (acc_ff),
      .divisor (len_ff),
      .stat    (iter_stat)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS)) else $error("waypoint count beyond table depth");
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == CMD_TICK) |=> state_ff != ST_IDLE)
      else $error("tick word produced no result");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the done state");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && (state_ff != ST_DONE) && (state_ff != ST_RD_CUR) &&
      (state_ff != ST_LD_CUR)
      |-> (CNT_W'(cur_idx_ff) < count_ff) && (CNT_W'(nxt_idx_ff) < count_ff))
      else $error("waypoint index out of range during motion");

endmodule

// ===== tb/sv/waypoint_path_follower_checker.sv =====
// Checker of the waypoint path follower: follows the channels, predicts results and compares.
`timescale 1ns / 100ps
module waypoint_path_follower_checker import wpf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [CMD_W-1:0]   req_tuser,
   input  logic [REQ_D_W-1:0] req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic               rsp_tuser,
   input  logic [RSP_D_W-1:0] rsp_tdata,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_D_W-1:0] csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [SCALE_W-1:0] sw;
      logic [SCALE_W-1:0] sh;
   } position_type;

   position_type position_queue[$];

   logic               cfg_enabled;
   logic [SPEED_W-1:0] cfg_speed;
   logic               cfg_ping_pong;
   logic [TIME_W-1:0]  cfg_start_delay;
   logic               cfg_start_paused;

   point_type         path[MAX_POINTS];
   int unsigned       count;
   int unsigned       cur_idx;
   logic              forward;
   logic [TIME_W-1:0] travel;
   logic [TIME_W-1:0] dwell_time;
   logic [TIME_W-1:0] delay_time;
   logic              halted;

   assign pending = position_queue.size();

   function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, longint unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[TIME_W-1:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bit_val;
      r = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= r + bit_val) begin
            v -= r + bit_val;
            r = (r >> 1) + bit_val;
         end else begin
            r >>= 1;
         end
         bit_val >>= 2;
      end
      return r;
   endfunction

   function automatic int unsigned following_index();
      if (cfg_ping_pong && !forward) return (cur_idx == 0) ? count - 1 : cur_idx - 1;
      return (cur_idx + 1) % count;
   endfunction

   function automatic longint unsigned segment_length(int unsigned a, int unsigned b);
      longint dx, dy;
      dx = longint'($signed(path[b].x)) - longint'($signed(path[a].x));
      dy = longint'($signed(path[b].y)) - longint'($signed(path[a].y));
      return int_sqrt(longint'(dx * dx) + longint'(dy * dy));
   endfunction

   function automatic logic [COORD_W-1:0] interpolate(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                                       longint unsigned d, longint unsigned len);
      longint sa, delta, q;
      longint unsigned mag;
      sa = longint'($signed(a));
      delta = longint'($signed(b)) - sa;
      mag = (delta < 0) ? -delta : delta;
      q = mag * d / len;
      return (delta < 0) ? COORD_W'(sa - q) : COORD_W'(sa + q);
   endfunction

   function automatic logic [SCALE_W-1:0] blend(logic [SCALE_W-1:0] a, logic [SCALE_W-1:0] b,
                                                 longint unsigned d, longint unsigned len);
      longint unsigned num;
      num = longint'(a) * (len - d) + longint'(b) * d;
      return SCALE_W'(num / len);
   endfunction

   function automatic position_type tick_position(logic [TICK_W-1:0] tick_length);
      position_type p;
      logic [TIME_W-1:0] dt;
      int unsigned c, n;
      longint unsigned len, d;
      p = '{valid: 1'b0, px: '0, py: '0, sw: SCALE_ONE, sh: SCALE_ONE};
      if (cfg_enabled && count > 1) begin
         dt = halted ? '0 : TIME_W'(tick_length);
         if (cur_idx >= count) cur_idx = 0;
         if (delay_time > cfg_start_delay) begin
            c = cur_idx;
            if (dwell_time > path[c].dwell) begin
               n = following_index();
               len = segment_length(c, n);
               travel = sat_add(travel, (longint'(cfg_speed) * dt) >> 16);
               if (longint'(travel) >= len) begin
                  travel -= TIME_W'(len);
                  dwell_time = '0;
                  if (cfg_ping_pong) begin
                     if (forward && n == count - 1) forward = 1'b0;
                     else if (!forward && n == 0) forward = 1'b1;
                  end
                  cur_idx = n;
                  c = n;
                  n = following_index();
                  len = segment_length(c, n);
               end
               p.valid = 1'b1;
               if (len == 0) begin
                  p.px = path[c].x;
                  p.py = path[c].y;
                  p.sw = path[c].width;
                  p.sh = path[c].height;
               end else begin
                  d = (longint'(travel) < len) ? longint'(travel) : len;
                  p.px = interpolate(path[c].x, path[n].x, d, len);
                  p.py = interpolate(path[c].y, path[n].y, d, len);
                  p.sw = blend(path[c].width, path[n].width, d, len);
                  p.sh = blend(path[c].height, path[n].height, d, len);
               end
            end else begin
               p.valid = 1'b1;
               p.px = path[c].x;
               p.py = path[c].y;
               dwell_time = sat_add(dwell_time, dt);
            end
         end else begin
            delay_time = sat_add(delay_time, dt);
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      position_type got, want;
      if (reset) begin
         cfg_enabled = 1'b1;
         cfg_speed = '0;
         cfg_ping_pong = 1'b0;
         cfg_start_delay = '0;
         cfg_start_paused = 1'b0;
         count = 0;
         cur_idx = 0;
         forward = 1'b1;
         travel = '0;
         dwell_time = '0;
         delay_time = '0;
         halted = 1'b0;
         position_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_ENABLED:      cfg_enabled = csr_wdata[0];
               REG_SPEED:        cfg_speed = csr_wdata[SPEED_W-1:0];
               REG_PING_PONG:    cfg_ping_pong = csr_wdata[0];
               REG_START_DELAY:  cfg_start_delay = csr_wdata;
               REG_START_PAUSED: cfg_start_paused = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[23:0], rsp_tdata[47:24], rsp_tdata[63:48],
                   rsp_tdata[79:64]};
            if (position_queue.size() == 0) begin
               $error("unexpected result word");
               fail_count++;
            end else begin
               want = position_queue.pop_front();
               if (got.valid !== want.valid) begin
                  $error("position_valid: expected %0d, got %0d", want.valid, got.valid);
                  fail_count++;
               end
               if (got.px !== want.px) begin
                  $error("pos_x: expected %h, got %h", want.px, got.px);
                  fail_count++;
               end
               if (got.py !== want.py) begin
                  $error("pos_y: expected %h, got %h", want.py, got.py);
                  fail_count++;
               end
               if (got.sw !== want.sw) begin
                  $error("scale_x: expected %h, got %h", want.sw, got.sw);
                  fail_count++;
               end
               if (got.sh !== want.sh) begin
                  $error("scale_y: expected %h, got %h", want.sh, got.sh);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               CMD_TICK: position_queue.insert(position_queue.size(),
                                               tick_position(req_tdata[15:0]));
               CMD_PUSH: begin
                  if (count < MAX_POINTS) begin
                     path[count] = '{x: req_tdata[39:16], y: req_tdata[63:40],
                                     dwell: req_tdata[95:64], width: req_tdata[111:96],
                                     height: req_tdata[127:112]};
                     count++;
                  end
               end
               CMD_CLEAR: count = 0;
               CMD_PAUSE: halted = !req_tdata[128];
               CMD_RESTART: begin
                  forward = 1'b1;
                  cur_idx = 0;
                  travel = '0;
                  dwell_time = '0;
                  delay_time = '0;
                  halted = cfg_start_paused;
               end
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/waypoint_path_follower_tb.sv =====
// Testbench top of the waypoint path follower: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module waypoint_path_follower_tb;
   import wpf_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [CMD_W-1:0]   req_tuser = CMD_TICK;
   logic [REQ_D_W-1:0] req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic               rsp_tuser;
   logic [RSP_D_W-1:0] rsp_tdata;
   logic               csr_we = 1'b0;
   logic [CSR_A_W-1:0] csr_addr = REG_ENABLED;
   logic [CSR_D_W-1:0] csr_wdata = '0;
   int                 fail_count;
   int                 pending;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 cycles = 0;

   always #10 clock = ~clock;

   waypoint_path_follower dut (.*);

   waypoint_path_follower_checker checker_inst (.*);

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_word(logic [CMD_W-1:0] cmd, logic [REQ_D_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic hold_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      hold_idle();
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_A_W-1:0] addr, logic [CSR_D_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [REQ_D_W-1:0] point_word(logic [23:0] x, logic [23:0] y,
                                                     logic [31:0] dwell, logic [15:0] w,
                                                     logic [15:0] h);
      logic [REQ_D_W-1:0] v;
      v = '0;
      v[39:16] = x;
      v[63:40] = y;
      v[95:64] = dwell;
      v[111:96] = w;
      v[127:112] = h;
      return v;
   endfunction

   function automatic logic [23:0] coord();
      int v;
      if ($urandom_range(4) == 0) return 24'($urandom);
      v = int'($urandom_range(40000)) - 20000;
      return v[23:0];
   endfunction

   task automatic random_word(output logic [CMD_W-1:0] cmd, output logic [REQ_D_W-1:0] data);
      int r;
      r = $urandom_range(99);
      data = REQ_D_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (r < 55) begin
         cmd = CMD_TICK;
      end else if (r < 72) begin
         cmd = CMD_PUSH;
         data[39:16] = coord();
         data[63:40] = coord();
         data[95:64] = ($urandom_range(7) == 0) ? $urandom : $urandom_range(100000);
      end else if (r < 76) begin
         cmd = CMD_CLEAR;
      end else if (r < 86) begin
         cmd = CMD_PAUSE;
         data[128] = ($urandom_range(3) != 0);
      end else if (r < 91) begin
         cmd = CMD_RESTART;
      end else if (r < 94) begin
         cmd = CMD_W'($urandom_range(7, 5));
      end else begin
         cmd = CMD_W'($urandom_range(4));
      end
   endtask

   initial begin
      logic [CMD_W-1:0]   cmd;
      logic [REQ_D_W-1:0] data;
      int                 sent;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(REG_ENABLED, 32'd1);
      write_reg(REG_SPEED, 32'hFFFFFF);
      write_reg(REG_PING_PONG, 32'd1);
      write_reg(REG_START_DELAY, 32'd0);
      write_reg(REG_START_PAUSED, 32'd0);

      // Path with a full-scale segment, a zero-length segment and a backward run.
      send_word(CMD_TICK, 136'hFFFF);
      send_word(CMD_PUSH, point_word(24'h800000, 24'h7FFFFF, 32'd0, 16'hFFFF, 16'h0000));
      send_word(CMD_TICK, 136'hFFFF);
      send_word(CMD_PUSH, point_word(24'h7FFFFF, 24'h800000, 32'hFFFFFFFF, 16'h0000, 16'hFFFF));
      send_word(CMD_PUSH, point_word(24'h7FFFFF, 24'h800000, 32'd0, 16'h0100, 16'h0100));
      send_word(CMD_TICK, 136'h0);
      repeat (4) send_word(CMD_TICK, 136'hFFFF);
      send_word(CMD_PAUSE, 136'h0);
      send_word(CMD_TICK, 136'hFFFF);
      send_word(CMD_PAUSE, {7'd0, 1'b1, 128'd0});
      send_word(CMD_TICK, 136'hFFFF);
      send_word(CMD_RESTART, 136'h0);
      send_word(CMD_TICK, 136'h1);
      send_word(3'd7, '1);
      send_word(CMD_CLEAR, 136'h0);
      send_word(CMD_TICK, 136'hFFFF);
      send_word(CMD_PUSH, point_word(24'h000100, 24'h000000, 32'd0, 16'd256, 16'd512));
      send_word(CMD_TICK, 136'hFFFF);

      for (int blk = 0; blk < 6; blk++) begin
         wait_drained();
         send_idle_pct = (blk < 2) ? 12 : (blk < 4) ? 78 : 0;
         recv_idle_pct = (blk < 2) ? 78 : (blk < 4) ? 12 : 0;
         write_reg(REG_ENABLED, (blk == 3) ? 32'd0 : 32'd1);
         write_reg(REG_SPEED, (blk == 0) ? 32'hFFFFFF : (blk == 5) ? 32'd0
                                         : 32'($urandom_range(24'h40000)));
         write_reg(REG_PING_PONG, 32'(blk % 2));
         write_reg(REG_START_DELAY, (blk == 4) ? 32'hFFFFFFFF
                                               : (blk == 2) ? 32'd0 : $urandom_range(200000));
         write_reg(REG_START_PAUSED, 32'(blk == 1));
         sent = 0;
         while (sent < 80) begin
            if (sent == 40) begin
               hold_idle();
               while (pending != 0) @(negedge clock);
            end
            random_word(cmd, data);
            send_word(cmd, data);
            if (cmd <= CMD_RESTART) sent++;
         end
      end

      wait_drained();
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
